// ----- rtl/hts_pkg.sv -----
package hts_pkg;

   localparam int PatCount = 4;
   localparam int PatMax   = 8;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_DELTA = 8'h20;

   // Tag prefixes, one row each: "<script", "</script", "<style", "</style".
   localparam logic [7:0] PAT_TEXT [PatCount][PatMax] = '{
      '{8'h3C, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74, 8'h00},
      '{8'h3C, 8'h2F, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74},
      '{8'h3C, 8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h00, 8'h00},
      '{8'h3C, 8'h2F, 8'h73, 8'h74, 8'h79, 8'h6C, 8'h65, 8'h00}
   };
   localparam logic [3:0] PAT_LEN [PatCount] = '{4'd7, 4'd8, 4'd6, 4'd7};
   // An opening prefix starts suppression, a closing one ends it.
   localparam logic PAT_SETS [PatCount] = '{1'b1, 1'b0, 1'b1, 1'b0};

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_text;
   } hts_result_type;

endpackage

// ----- rtl/html_tag_stripper.sv -----
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_in_byte[7:0], req_is_last
// rsp_      out        rsp_valid/rsp_stall  rsp_out_byte[7:0], rsp_byte_valid, rsp_end_of_text
//
// One byte is taken per clock while req_stall is low; its result, if it has one, goes
// to the output register, or to the skid register while that one is stalled. The tag
// and prefix state is updated in the same cycle, so the sustained rate is one byte per clock.
// Reset is synchronous and active high and clears all control state.
// A two-entry output (result register plus skid register) lets one more byte in while
// a result is stalled; req_stall comes straight from the skid register.
module html_tag_stripper
   import hts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_end_of_text
);

   // Parse state.
   logic       inside_tag_ff, inside_tag_in;
   logic       inside_script_ff, inside_script_in;
   logic [3:0] match_position_ff, match_position_in;
   logic [3:0] pattern_alive_ff, pattern_alive_in;
   logic       any_emitted_ff, any_emitted_in;
   logic       last_was_space_ff, last_was_space_in;

   // Output register and skid register.
   logic           rsp_valid_ff, rsp_valid_in;
   hts_result_type rsp_data_ff, rsp_data_in;
   logic           skid_valid_ff, skid_valid_in;
   hts_result_type skid_data_ff, skid_data_in;

   logic           req_xfer;
   logic           out_free;
   logic [7:0]     folded;
   logic [3:0]     alive_mid;
   logic           script_mid;
   logic [3:0]     pos_mid;
   logic           emit;
   logic [7:0]     emit_byte;
   logic           res_valid;
   hts_result_type res_data;

   // The skid register is the only thing that holds off the input side.
   assign req_stall = skid_valid_ff;
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Only A to Z fold to lower case; everything else compares as is.
   assign folded = (req_in_byte >= CHAR_UP_A && req_in_byte <= CHAR_UP_Z) ?
                   req_in_byte + CASE_DELTA : req_in_byte;

   // Prefix matching: each live pattern compares the folded byte at the current
   // position. A pattern that completes sets or clears suppression and retires.
   always_comb begin
      alive_mid  = pattern_alive_ff;
      script_mid = inside_script_ff;
      pos_mid    = match_position_ff;
      if (pattern_alive_ff != 4'd0) begin
         for (int k = 0; k < PatCount; k++) begin
            if (pattern_alive_ff[k]) begin
               if (match_position_ff < PAT_LEN[k] &&
                   folded == PAT_TEXT[k][match_position_ff[2:0]]) begin
                  if (match_position_ff + 4'd1 == PAT_LEN[k]) begin
                     script_mid   = PAT_SETS[k];
                     alive_mid[k] = 1'b0;
                  end
               end else begin
                  alive_mid[k] = 1'b0;
               end
            end
         end
         if (alive_mid != 4'd0 && match_position_ff != 4'hF) begin
            pos_mid = match_position_ff + 4'd1;
         end else begin
            pos_mid = 4'd0;
         end
      end
   end

   // Byte classification and the next parse state. A '<' outside a tag starts a
   // fresh prefix match; a '>' closes the tag and may insert a single space.
   always_comb begin
      inside_tag_in     = inside_tag_ff;
      inside_script_in  = inside_script_ff;
      match_position_in = match_position_ff;
      pattern_alive_in  = pattern_alive_ff;
      any_emitted_in    = any_emitted_ff;
      last_was_space_in = last_was_space_ff;
      emit              = 1'b0;
      emit_byte         = 8'd0;

      if (req_xfer) begin
         inside_script_in  = script_mid;
         match_position_in = pos_mid;
         pattern_alive_in  = alive_mid;

         if (req_in_byte == CHAR_LT) begin
            if (!inside_tag_ff) begin
               pattern_alive_in  = 4'hF;
               match_position_in = 4'd1;
            end
            inside_tag_in = 1'b1;
         end else if (req_in_byte == CHAR_GT) begin
            inside_tag_in = 1'b0;
            if (any_emitted_ff && !last_was_space_ff) begin
               emit      = 1'b1;
               emit_byte = CHAR_SPACE;
            end
         end else if (!inside_tag_ff && !script_mid) begin
            // Suppression follows the updated flag, as the prefix check runs first.
            emit      = 1'b1;
            emit_byte = req_in_byte;
         end

         if (emit) begin
            any_emitted_in    = 1'b1;
            last_was_space_in = (emit_byte == CHAR_SPACE);
         end

         // The document ends here: everything starts over for the next one.
         if (req_is_last) begin
            inside_tag_in     = 1'b0;
            inside_script_in  = 1'b0;
            match_position_in = 4'd0;
            pattern_alive_in  = 4'd0;
            any_emitted_in    = 1'b0;
            last_was_space_in = 1'b0;
         end
      end
   end

   // A transfer yields a result when a byte is emitted or the document ends.
   assign res_valid            = req_xfer && (emit || req_is_last);
   assign res_data.out_byte    = emit_byte;
   assign res_data.byte_valid  = emit;
   assign res_data.end_of_text = req_is_last;

   // Output staging. A waiting skid entry moves up first; new results go to the
   // output register when it is free and to the skid register otherwise.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_data;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_tag_ff     <= 1'b0;
         inside_script_ff  <= 1'b0;
         match_position_ff <= 4'd0;
         pattern_alive_ff  <= 4'd0;
         any_emitted_ff    <= 1'b0;
         last_was_space_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         inside_tag_ff     <= inside_tag_in;
         inside_script_ff  <= inside_script_in;
         match_position_ff <= match_position_in;
         pattern_alive_ff  <= pattern_alive_in;
         any_emitted_ff    <= any_emitted_in;
         last_was_space_ff <= last_was_space_in;
         rsp_valid_ff      <= rsp_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_data_ff.out_byte;
   assign rsp_byte_valid  = rsp_data_ff.byte_valid;
   assign rsp_end_of_text = rsp_data_ff.end_of_text;

   // The skid register only fills behind a stalled output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held while output register empty");

   // A prefix match is in progress exactly when the position is nonzero.
   a_match_consistent: assert property (@(posedge clock) disable iff (reset)
      (pattern_alive_ff != 4'd0) == (match_position_ff != 4'd0))
      else $error("match position and live patterns disagree");

   // No prefix is longer than eight bytes.
   a_match_bound: assert property (@(posedge clock) disable iff (reset)
      match_position_ff <= 4'd8)
      else $error("match position beyond longest prefix");

   // The last byte of a document leaves the parser in its starting state.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_is_last) |=>
         (!inside_tag_ff && !inside_script_ff && !any_emitted_ff &&
          pattern_alive_ff == 4'd0))
      else $error("parse state not cleared after last byte");

endmodule

// ----- test/html_tag_stripper_tb.sv -----
module html_tag_stripper_tb;
   import hts_pkg::*;

   // The run ends in failure if it is still going after this many cycles. The slowest
   // correct run (every byte waiting out a full sender gap and a full receiver stall,
   // plus the long hold-off) stays well under it.
   localparam int CYCLE_LIMIT  = 500000;
   // Length of the long receiver hold-off, and how many bytes go through before it.
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 500;
   // Near the end of the feed no idling is done on either side.
   localparam int CALM_TAIL    = 150;
   localparam int RANDOM_BYTES = 1850;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } doc_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = '0;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_end_of_text;

   html_tag_stripper dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_end_of_text(rsp_end_of_text)
   );

   always #1 clock = ~clock;

   // Document bytes still to be offered, and the results the stripper owes us.
   doc_byte_type   feed_q[$];
   hts_result_type expected_text_q[$];

   int  total_bytes  = 0;
   int  taken_count  = 0;
   int  result_count = 0;
   int  fault_count  = 0;
   int  cycle_count  = 0;
   int  send_gap     = 0;
   int  stall_gap    = 0;
   logic req_taken   = 1'b0;
   logic hold_off    = 1'b0;

   // Our own copy of the stripper state.
   logic       in_tag;
   logic       in_suppress;
   logic [3:0] match_pos;
   logic [3:0] prefix_alive;
   logic       emitted_any;
   logic       prev_space;

   task automatic clear_strip_state();
      in_tag       = 1'b0;
      in_suppress  = 1'b0;
      match_pos    = '0;
      prefix_alive = '0;
      emitted_any  = 1'b0;
      prev_space   = 1'b0;
   endtask

   // Runs one accepted byte through the stripper state and queues the result it owes,
   // if any. The prefix matchers look at the byte before the '<' handling below can
   // restart them, so a '<' that opens a tag only arms them for the following byte.
   task automatic predict_visible(input logic [7:0] b, input logic last);
      logic [7:0]     folded;
      logic [3:0]     pos;
      logic           emit;
      logic [7:0]     shown;
      hts_result_type owed;
      emit  = 1'b0;
      shown = '0;
      if (prefix_alive != '0) begin
         pos    = match_pos;
         folded = (b >= CHAR_UP_A && b <= CHAR_UP_Z) ? b + CASE_DELTA : b;
         for (int k = 0; k < PatCount; k++) begin
            if (prefix_alive[k]) begin
               if (pos < PAT_LEN[k] && folded == PAT_TEXT[k][pos[2:0]]) begin
                  // A complete prefix decides suppression and retires its matcher.
                  if (pos + 4'd1 == PAT_LEN[k]) begin
                     in_suppress     = PAT_SETS[k];
                     prefix_alive[k] = 1'b0;
                  end
               end else begin
                  prefix_alive[k] = 1'b0;
               end
            end
         end
         match_pos = (prefix_alive != '0 && pos < 4'd15) ? pos + 4'd1 : 4'd0;
      end

      if (b == CHAR_LT) begin
         // A '<' inside an open tag starts no new match.
         if (!in_tag) begin
            prefix_alive = 4'hF;
            match_pos    = 4'd1;
         end
         in_tag = 1'b1;
      end else if (b == CHAR_GT) begin
         // Every '>' may insert a space, even outside a tag or while suppressed.
         in_tag = 1'b0;
         if (emitted_any && !prev_space) begin
            emit  = 1'b1;
            shown = CHAR_SPACE;
         end
      end else if (!in_tag && !in_suppress) begin
         emit  = 1'b1;
         shown = b;
      end

      if (emit) begin
         emitted_any = 1'b1;
         prev_space  = (shown == CHAR_SPACE);
      end

      if (emit || last) begin
         owed.out_byte    = shown;
         owed.byte_valid  = emit;
         owed.end_of_text = last;
         expected_text_q.push_back(owed);
      end
      if (last)
         clear_strip_state();
   endtask

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------

   task automatic add_byte(input logic [7:0] b);
      doc_byte_type item;
      item.in_byte = b;
      item.is_last = 1'b0;
      feed_q.push_back(item);
   endtask

   task automatic add_string(input string s);
      for (int i = 0; i < s.len(); i++)
         add_byte(s[i]);
   endtask

   // Marks the most recently added byte as the end of its document.
   task automatic close_document();
      doc_byte_type item;
      item = feed_q.pop_back();
      item.is_last = 1'b1;
      feed_q.push_back(item);
   endtask

   function automatic string mixed_case(input string s);
      string t;
      t = s;
      for (int i = 0; i < t.len(); i++)
         if (t[i] >= "a" && t[i] <= "z" && $urandom_range(0, 1) == 1)
            t[i] = t[i] - CASE_DELTA;
      return t;
   endfunction

   // Any byte value except the two tag delimiters.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_LT || b == CHAR_GT)
         b = CHAR_SPACE;
      return b;
   endfunction

   // One random document. Most segments are text runs and complete tags, with the
   // script and style prefixes and near misses of them common among the tag names;
   // the rest are unclosed tags, stray closers and raw noise.
   task automatic add_random_document();
      string names[14];
      int    segments;
      int    run;
      names = '{"script", "/script", "style", "/style", "script", "style",
                "scrip", "/scrpt", "styl", "scriptx", "stylesheet", "/", "p", "div"};
      segments = $urandom_range(1, 10);
      for (int s = 0; s < segments; s++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               run = $urandom_range(1, 10);
               for (int i = 0; i < run; i++)
                  add_byte(($urandom_range(0, 3) == 0) ? CHAR_SPACE : plain_byte());
            end
            3, 4, 5, 6: begin
               add_byte(CHAR_LT);
               if ($urandom_range(0, 9) == 0)
                  add_byte(CHAR_LT);
               add_string(mixed_case(names[$urandom_range(0, 13)]));
               if ($urandom_range(0, 2) == 0) begin
                  add_byte(CHAR_SPACE);
                  run = $urandom_range(1, 5);
                  for (int i = 0; i < run; i++)
                     add_byte(($urandom_range(0, 7) == 0) ? CHAR_LT : plain_byte());
               end
               // Now and then the tag is left open.
               if ($urandom_range(0, 7) != 0)
                  add_byte(CHAR_GT);
            end
            7: begin
               run = $urandom_range(1, 3);
               for (int i = 0; i < run; i++)
                  add_byte(CHAR_GT);
            end
            default: begin
               run = $urandom_range(1, 6);
               for (int i = 0; i < run; i++)
                  add_byte(8'($urandom_range(0, 255)));
            end
         endcase
      end
      close_document();
   endtask

   // ------------------------------------------------------------------
   // Request side: acceptance is sampled at the rising edge, where the
   // byte also goes through the predictor; the next byte or an idle
   // cycle is set up at the falling edge.
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         predict_visible(req_in_byte, req_is_last);
         taken_count <= taken_count + 1;
      end
   end

   always @(negedge clock) begin : drive_req
      doc_byte_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // The previous transfer is done (or none was pending), so a new byte may be
         // offered. Otherwise the current one is held unchanged.
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (feed_q.size() > CALM_TAIL && $urandom_range(0, 15) == 0) begin
            // Start an idle burst of random length, this cycle included.
            send_gap  <= $urandom_range(0, 14);
            req_valid <= 1'b0;
         end else if (feed_q.size() != 0) begin
            item = feed_q.pop_front();
            req_valid   <= 1'b1;
            req_in_byte <= item.in_byte;
            req_is_last <= item.is_last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result side: stall in random bursts, plus one long hold-off that
   // lets the output and skid registers fill so that req_stall rises
   // while bytes are still being offered.
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off) begin
         rsp_stall <= 1'b1;
      end else if (stall_gap > 0) begin
         stall_gap <= stall_gap - 1;
         rsp_stall <= 1'b1;
      end else if (feed_q.size() > CALM_TAIL && $urandom_range(0, 15) == 0) begin
         stall_gap <= $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      wait (taken_count >= HOLD_AFTER);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off = 1'b0;
   end

   // Each result transfer is checked against the oldest owed result.
   always @(posedge clock) begin : check_rsp
      hts_result_type got;
      hts_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.out_byte    = rsp_out_byte;
         got.byte_valid  = rsp_byte_valid;
         got.end_of_text = rsp_end_of_text;
         if (expected_text_q.size() == 0) begin
            if (fault_count < MAX_REPORTS)
               $display("result %0d arrived with none owed: byte=%02h valid=%b end=%b",
                        result_count, got.out_byte, got.byte_valid, got.end_of_text);
            fault_count++;
         end else begin
            want = expected_text_q.pop_front();
            if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                got.end_of_text !== want.end_of_text) begin
               if (fault_count < MAX_REPORTS) begin
                  $display("result %0d mismatch: expected byte=%02h valid=%b end=%b",
                           result_count, want.out_byte, want.byte_valid,
                           want.end_of_text);
                  $display("result %0d mismatch: got byte=%02h valid=%b end=%b",
                           result_count, got.out_byte, got.byte_valid,
                           got.end_of_text);
               end
               fault_count++;
            end
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus, reset and end of run.
   // ------------------------------------------------------------------

   initial begin
      clear_strip_state();

      // A document that is a lone '<': it ends with nothing shown.
      add_byte(CHAR_LT);
      close_document();

      // A leading '>' inserts no space; a zero byte is ordinary text; a '>' outside
      // any tag inserts a space, but not twice in a row; a style tag in mixed case
      // suppresses text, a '>' under suppression still follows the space rule, and
      // the closing style tag ends the document.
      add_byte(CHAR_GT);
      add_byte(8'h00);
      add_byte(CHAR_GT);
      add_byte(CHAR_GT);
      add_byte(8'hFF);
      add_string("<STyLe>");
      add_byte("w");
      add_byte(CHAR_GT);
      add_string("</style>");
      close_document();

      while (feed_q.size() < RANDOM_BYTES)
         add_random_document();
      total_bytes = feed_q.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every byte to be taken and every owed result to arrive, then give
      // the block a few more cycles in case it sends anything extra.
      while (taken_count < total_bytes || expected_text_q.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);

      if (fault_count == 0 && expected_text_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/hts_pkg.sv
rtl/html_tag_stripper.sv
test/html_tag_stripper_tb.sv
